// ===== design/bti_pkg.sv =====
// shared types and constants for the bilinear table interpolator
package bti_pkg;

  localparam int VAL_W    = 32;
  localparam int WGT_W    = 21;
  localparam int WFRAC_W  = 20;
  localparam int MUL_W    = 33;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int ACC_W    = 55;
  localparam int POS_W    = 64;
  localparam int POS_FRAC = 36;
  localparam int IP_W     = POS_W - POS_FRAC;
  localparam int CFG_IDX_W = 3;

  localparam logic [WGT_W-1:0] W_ONE = WGT_W'(1) << WFRAC_W;

  localparam logic [CFG_IDX_W-1:0] CFG_DENSITY_ORIGIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DENSITY_INV_STEP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DENSITY_POINTS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_ORIGIN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_INV_STEP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_POINTS      = 3'd5;

  typedef enum logic [1:0] {
    ACT_LOAD     = 2'd0,
    ACT_EVAL_ONE = 2'd1,
    ACT_EVAL_ALL = 2'd2,
    ACT_NONE     = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2
  } acc_op_t;

  typedef struct packed {
    logic    mul_en;
    acc_op_t acc_op;
  } mac_ctrl_t;

  typedef struct packed {
    action_t            action;
    logic [3:0]         quantity;
    logic [7:0]         row_density;
    logic [6:0]         row_temp;
    logic signed [31:0] entry_value;
    logic signed [31:0] log_density;
    logic signed [31:0] log_temp;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [3:0]         result_quantity;
    logic               last;
    logic               out_of_range;
  } out_item_t;

endpackage

// ===== design/bti_axis.sv =====
// axis locate: cell index, upper weight and clamp flag from the scaled position
module bti_axis #(
  parameter int POINTS_MAX = 256,
  parameter int CFG_W      = 9,
  parameter int IW         = 8
) (
  input  logic                         neg,
  input  logic [bti_pkg::POS_W-1:0]    pos,
  input  logic [CFG_W-1:0]             points,
  output logic [IW-1:0]                idx,
  output logic [bti_pkg::WGT_W-1:0]    w1,
  output logic                         oor
);

  localparam int MW = $clog2(POINTS_MAX + 1);
  localparam int NW = (CFG_W > MW) ? CFG_W : MW;

  logic [NW-1:0]                npts;
  logic [NW-1:0]                last_pt;
  logic [bti_pkg::IP_W-1:0]     ip;
  logic [bti_pkg::IP_W-1:0]     last_ext;
  logic [bti_pkg::POS_FRAC-1:0] frac;

  always_comb begin
    if (NW'(points) < NW'(2)) begin
      npts = NW'(2);
    end else if (NW'(points) > NW'(POINTS_MAX)) begin
      npts = NW'(POINTS_MAX);
    end else begin
      npts = NW'(points);
    end
    last_pt  = npts - NW'(1);
    last_ext = bti_pkg::IP_W'(last_pt);
    ip       = pos[bti_pkg::POS_W-1:bti_pkg::POS_FRAC];
    frac     = pos[bti_pkg::POS_FRAC-1:0];
    if (neg) begin
      idx = '0;
      w1  = '0;
      oor = 1'b1;
    end else if (ip > last_ext || (ip == last_ext && frac != '0)) begin
      idx = IW'(npts - NW'(2));
      w1  = bti_pkg::W_ONE;
      oor = 1'b1;
    end else if (ip == last_ext) begin
      idx = IW'(npts - NW'(2));
      w1  = bti_pkg::W_ONE;
      oor = 1'b0;
    end else begin
      idx = IW'(ip);
      w1  = {1'b0, pos[bti_pkg::POS_FRAC-1:bti_pkg::POS_FRAC-bti_pkg::WFRAC_W]};
      oor = 1'b0;
    end
  end

endmodule

// ===== design/bti_mac.sv =====
// shared signed multiplier with registered product and accumulator
module bti_mac (
  input  logic                                clk,
  input  bti_pkg::mac_ctrl_t                  ctrl,
  input  logic signed [bti_pkg::MUL_W-1:0]    mul_a,
  input  logic signed [bti_pkg::MUL_W-1:0]    mul_b,
  output logic signed [bti_pkg::PROD_W-1:0]   prod,
  output logic signed [bti_pkg::ACC_W-1:0]    acc
);

  logic signed [bti_pkg::PROD_W-1:0] prod_r;
  logic signed [bti_pkg::ACC_W-1:0]  acc_r;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    case (ctrl.acc_op)
      bti_pkg::ACC_LOAD: acc_r <= prod_r[bti_pkg::ACC_W-1:0];
      bti_pkg::ACC_ADD:  acc_r <= acc_r + prod_r[bti_pkg::ACC_W-1:0];
      default:           acc_r <= acc_r;
    endcase
  end

  assign prod = prod_r;
  assign acc  = acc_r;

endmodule

// ===== design/bti_table_mem.sv =====
// value table: one write port, one registered read port
module bti_table_mem #(
  parameter int DEPTH = 425984,
  parameter int AW    = 19
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [AW-1:0]                    waddr,
  input  logic [bti_pkg::VAL_W-1:0]        wdata,
  input  logic [AW-1:0]                    raddr,
  output logic [bti_pkg::VAL_W-1:0]        rdata
);

  logic [bti_pkg::VAL_W-1:0] mem [DEPTH];
  logic [bti_pkg::VAL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/bilinear_table_interpolator.sv =====
// top level: bilinear interpolation over a uniform log density by log temperature table
// load items write a table entry; evaluate items first locate the cell on both axes
// in states S_LOC_D, S_LOC_T, S_LOC_F and S_BASE, then for each quantity run the blend
// steps and an emit step: four corner reads through the single table read port and six
// products through the one shared multiplier
// synchronous active-low reset clears control and sets the configuration to its defaults; the table is not cleared
module bilinear_table_interpolator #(
  parameter int NUM_QUANTITIES = 13,
  parameter int DENSITY_POINTS = 256,
  parameter int TEMP_POINTS    = 128
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  bti_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output bti_pkg::out_item_t                out_data,
  input  logic                              cfg_we,
  input  logic [bti_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_wdata
);

  localparam int PLANE = DENSITY_POINTS * TEMP_POINTS;
  localparam int DEPTH = NUM_QUANTITIES * PLANE;
  localparam int AW    = $clog2(DEPTH);
  localparam int DIW   = (DENSITY_POINTS > 2) ? $clog2(DENSITY_POINTS - 1) : 1;
  localparam int TIW   = (TEMP_POINTS > 2) ? $clog2(TEMP_POINTS - 1) : 1;
  localparam logic [3:0] STEP_LAST = 4'd8;
  localparam logic signed [bti_pkg::ACC_W-1:0] HALF_LSB =
    bti_pkg::ACC_W'(1) << (bti_pkg::WFRAC_W - 1);
  localparam logic signed [bti_pkg::ACC_W-1:0] SAT_MAX = bti_pkg::ACC_W'(32'h7fff_ffff);
  localparam logic signed [bti_pkg::ACC_W-1:0] SAT_MIN =
    -(bti_pkg::ACC_W'(32'h7fff_ffff)) - bti_pkg::ACC_W'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOC_D,
    S_LOC_T,
    S_LOC_F,
    S_BASE,
    S_BLEND,
    S_EMIT
  } state_t;

  state_t state_r;

  logic signed [31:0] density_origin_r;
  logic [31:0]        density_inv_step_r;
  logic [8:0]         density_points_r;
  logic signed [31:0] temp_origin_r;
  logic [31:0]        temp_inv_step_r;
  logic [7:0]         temp_points_r;

  logic signed [31:0]  log_density_r;
  logic signed [31:0]  log_temp_r;
  logic [3:0]          q_r;
  logic [3:0]          last_q_r;
  logic [AW-1:0]       plane_r;
  logic [AW-1:0]       base_r;
  logic [DIW-1:0]      di_r;
  logic [TIW-1:0]      ti_r;
  logic [bti_pkg::WGT_W-1:0] wn1_r;
  logic [bti_pkg::WGT_W-1:0] wt1_r;
  logic                oor_r;
  logic [3:0]          step_r;
  logic signed [31:0]  lo_r;
  logic signed [31:0]  hi_r;
  logic                out_valid_r;
  bti_pkg::out_item_t  out_data_r;

  logic                 in_xfer;
  logic                 eval_go;
  logic [3:0]           first_q;
  logic signed [32:0]   diff_d;
  logic signed [32:0]   diff_t;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [AW-1:0]        mem_raddr;
  logic [AW-1:0]        addr00;
  logic [bti_pkg::VAL_W-1:0] mem_rdata;
  bti_pkg::mac_ctrl_t   mac_ctrl;
  logic signed [bti_pkg::MUL_W-1:0]  mul_a;
  logic signed [bti_pkg::MUL_W-1:0]  mul_b;
  logic signed [bti_pkg::PROD_W-1:0] prod;
  logic signed [bti_pkg::ACC_W-1:0]  acc;
  logic signed [bti_pkg::ACC_W-1:0]  rnd;
  logic signed [31:0]   final_val;
  logic [DIW-1:0]       d_idx;
  logic [TIW-1:0]       t_idx;
  logic [bti_pkg::WGT_W-1:0] d_w1;
  logic [bti_pkg::WGT_W-1:0] t_w1;
  logic                 d_oor;
  logic                 t_oor;
  logic signed [bti_pkg::MUL_W-1:0] wt0_op;
  logic signed [bti_pkg::MUL_W-1:0] wt1_op;
  logic signed [bti_pkg::MUL_W-1:0] rd_op;
  logic                 emit_ok;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign eval_go  = (in_data.action == bti_pkg::ACT_EVAL_ALL) ||
                    (in_data.action == bti_pkg::ACT_EVAL_ONE &&
                     32'(in_data.quantity) < NUM_QUANTITIES);
  assign first_q  = (in_data.action == bti_pkg::ACT_EVAL_ONE) ? in_data.quantity : 4'd0;

  assign diff_d = {log_density_r[31], log_density_r} - {density_origin_r[31], density_origin_r};
  assign diff_t = {log_temp_r[31], log_temp_r} - {temp_origin_r[31], temp_origin_r};

  assign mem_we = in_xfer && (in_data.action == bti_pkg::ACT_LOAD) &&
                  32'(in_data.quantity) < NUM_QUANTITIES &&
                  32'(in_data.row_density) < DENSITY_POINTS &&
                  32'(in_data.row_temp) < TEMP_POINTS;
  assign mem_waddr = AW'((32'(in_data.quantity) * DENSITY_POINTS + 32'(in_data.row_density))
                         * TEMP_POINTS + 32'(in_data.row_temp));
  assign addr00 = plane_r + base_r;

  assign wt0_op = bti_pkg::MUL_W'(bti_pkg::W_ONE - wt1_r);
  assign wt1_op = bti_pkg::MUL_W'(wt1_r);
  assign rd_op  = {mem_rdata[31], mem_rdata};

  // operand select and corner read schedule
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    mac_ctrl  = '{mul_en: 1'b0, acc_op: bti_pkg::ACC_HOLD};
    mem_raddr = addr00;
    case (state_r)
      S_LOC_D: begin
        mul_a           = diff_d;
        mul_b           = {1'b0, density_inv_step_r};
        mac_ctrl.mul_en = 1'b1;
      end
      S_LOC_T: begin
        mul_a           = diff_t;
        mul_b           = {1'b0, temp_inv_step_r};
        mac_ctrl.mul_en = 1'b1;
      end
      S_BLEND: begin
        case (step_r)
          4'd0: begin
            mem_raddr = addr00;
          end
          4'd1: begin
            mem_raddr       = addr00 + AW'(1);
            mul_a           = wt0_op;
            mul_b           = rd_op;
            mac_ctrl.mul_en = 1'b1;
          end
          4'd2: begin
            mem_raddr       = addr00 + AW'(TEMP_POINTS);
            mul_a           = wt1_op;
            mul_b           = rd_op;
            mac_ctrl.mul_en = 1'b1;
            mac_ctrl.acc_op = bti_pkg::ACC_LOAD;
          end
          4'd3: begin
            mem_raddr       = addr00 + AW'(TEMP_POINTS + 1);
            mul_a           = wt0_op;
            mul_b           = rd_op;
            mac_ctrl.mul_en = 1'b1;
            mac_ctrl.acc_op = bti_pkg::ACC_ADD;
          end
          4'd4: begin
            mul_a           = wt1_op;
            mul_b           = rd_op;
            mac_ctrl.mul_en = 1'b1;
            mac_ctrl.acc_op = bti_pkg::ACC_LOAD;
          end
          4'd5: begin
            mac_ctrl.acc_op = bti_pkg::ACC_ADD;
          end
          4'd6: begin
            mul_a           = bti_pkg::MUL_W'(bti_pkg::W_ONE - wn1_r);
            mul_b           = {lo_r[31], lo_r};
            mac_ctrl.mul_en = 1'b1;
          end
          4'd7: begin
            mul_a           = bti_pkg::MUL_W'(wn1_r);
            mul_b           = {hi_r[31], hi_r};
            mac_ctrl.mul_en = 1'b1;
            mac_ctrl.acc_op = bti_pkg::ACC_LOAD;
          end
          4'd8: begin
            mac_ctrl.acc_op = bti_pkg::ACC_ADD;
          end
          default: begin
            mac_ctrl.acc_op = bti_pkg::ACC_HOLD;
          end
        endcase
      end
      default: begin
        mac_ctrl.mul_en = 1'b0;
      end
    endcase
  end

  // round half up, dropping the Q.20 weight fraction, and saturate to signed 32 bits
  assign rnd = (acc + HALF_LSB) >>> bti_pkg::WFRAC_W;
  always_comb begin
    if (rnd > SAT_MAX) begin
      final_val = 32'sh7fff_ffff;
    end else if (rnd < SAT_MIN) begin
      final_val = 32'sh8000_0000;
    end else begin
      final_val = rnd[31:0];
    end
  end

  assign emit_ok = !out_valid_r || out_ready;

  bti_table_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_data.entry_value),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bti_mac u_mac (
    .clk   (clk),
    .ctrl  (mac_ctrl),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (prod),
    .acc   (acc)
  );

  bti_axis #(
    .POINTS_MAX (DENSITY_POINTS),
    .CFG_W      (9),
    .IW         (DIW)
  ) u_axis_d (
    .neg    (diff_d[32]),
    .pos    (prod[bti_pkg::POS_W-1:0]),
    .points (density_points_r),
    .idx    (d_idx),
    .w1     (d_w1),
    .oor    (d_oor)
  );

  bti_axis #(
    .POINTS_MAX (TEMP_POINTS),
    .CFG_W      (8),
    .IW         (TIW)
  ) u_axis_t (
    .neg    (diff_t[32]),
    .pos    (prod[bti_pkg::POS_W-1:0]),
    .points (temp_points_r),
    .idx    (t_idx),
    .w1     (t_w1),
    .oor    (t_oor)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= S_IDLE;
      out_valid_r        <= 1'b0;
      step_r             <= '0;
      density_origin_r   <= '0;
      density_inv_step_r <= 32'd65536;
      density_points_r   <= 9'(DENSITY_POINTS);
      temp_origin_r      <= '0;
      temp_inv_step_r    <= 32'd65536;
      temp_points_r      <= 8'(TEMP_POINTS);
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bti_pkg::CFG_DENSITY_ORIGIN:   density_origin_r   <= cfg_wdata;
          bti_pkg::CFG_DENSITY_INV_STEP: density_inv_step_r <= cfg_wdata;
          bti_pkg::CFG_DENSITY_POINTS:   density_points_r   <= cfg_wdata[8:0];
          bti_pkg::CFG_TEMP_ORIGIN:      temp_origin_r      <= cfg_wdata;
          bti_pkg::CFG_TEMP_INV_STEP:    temp_inv_step_r    <= cfg_wdata;
          bti_pkg::CFG_TEMP_POINTS:      temp_points_r      <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_ready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer && eval_go) begin
            log_density_r <= in_data.log_density;
            log_temp_r    <= in_data.log_temp;
            q_r           <= first_q;
            last_q_r      <= (in_data.action == bti_pkg::ACT_EVAL_ONE) ?
                             in_data.quantity : 4'(NUM_QUANTITIES - 1);
            plane_r       <= AW'(32'(first_q) * PLANE);
            state_r       <= S_LOC_D;
          end
        end
        S_LOC_D: begin
          state_r <= S_LOC_T;
        end
        S_LOC_T: begin
          di_r    <= d_idx;
          wn1_r   <= d_w1;
          oor_r   <= d_oor;
          state_r <= S_LOC_F;
        end
        S_LOC_F: begin
          ti_r    <= t_idx;
          wt1_r   <= t_w1;
          oor_r   <= oor_r | t_oor;
          state_r <= S_BASE;
        end
        S_BASE: begin
          base_r  <= AW'(32'(di_r) * TEMP_POINTS + 32'(ti_r));
          step_r  <= '0;
          state_r <= S_BLEND;
        end
        S_BLEND: begin
          if (step_r == 4'd4) begin
            lo_r <= rnd[31:0];
          end
          if (step_r == 4'd6) begin
            hi_r <= rnd[31:0];
          end
          if (step_r == STEP_LAST) begin
            state_r <= S_EMIT;
          end else begin
            step_r <= step_r + 4'd1;
          end
        end
        S_EMIT: begin
          if (emit_ok) begin
            out_valid_r                <= 1'b1;
            out_data_r.result_value    <= final_val;
            out_data_r.result_quantity <= q_r;
            out_data_r.last            <= (q_r == last_q_r);
            out_data_r.out_of_range    <= oor_r;
            if (q_r == last_q_r) begin
              state_r <= S_IDLE;
            end else begin
              q_r     <= q_r + 4'd1;
              plane_r <= plane_r + AW'(PLANE);
              step_r  <= '0;
              state_r <= S_BLEND;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_emit_only: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("result appeared outside the emit step");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BLEND) |-> (step_r <= STEP_LAST))
    else $error("blend step counter overran");

  a_quantity_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (32'(out_data_r.result_quantity) < NUM_QUANTITIES))
    else $error("result quantity beyond table");

  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_IDLE))
    else $error("table write while evaluating");

endmodule

// ===== tb/testbench.sv =====
// testbench for the bilinear table interpolator: predicts every blend and checks each result
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NQ = 13;
  localparam int DP = 256;
  localparam int TP = 128;
  localparam longint W_UNIT = longint'(1) << bti_pkg::WFRAC_W;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  bti_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  bti_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [bti_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  logic signed [31:0] dens_origin = '0;
  logic [31:0] dens_step = 32'd65536;
  logic [8:0] dens_pts = 9'd256;
  logic signed [31:0] temp_origin = '0;
  logic [31:0] temp_step = 32'd65536;
  logic [7:0] temp_pts = 8'd128;

  int entry_mem[int];
  bti_pkg::out_item_t expected_blends[$];
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic out_hold = 1'b0;
  bit offering = 1'b0;

  bilinear_table_interpolator #(
    .NUM_QUANTITIES(NQ),
    .DENSITY_POINTS(DP),
    .TEMP_POINTS(TP)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int entry_index(input int unsigned q, input int unsigned d,
                                     input int unsigned t);
    return int'((q * DP + d) * TP + t);
  endfunction

  function automatic int unsigned effective_points(input int unsigned v, input int unsigned maxp);
    if (v < 2) return 2;
    if (v > maxp) return maxp;
    return v;
  endfunction

  function automatic longint round_q20(input longint x);
    return (x + (longint'(1) << (bti_pkg::WFRAC_W - 1))) >>> bti_pkg::WFRAC_W;
  endfunction

  function automatic int unsigned find_cell(input logic signed [31:0] query,
                                            input logic signed [31:0] origin,
                                            input logic [31:0] inv_step,
                                            input int unsigned npts,
                                            output longint w_hi, inout bit clamped);
    longint diff;
    logic [63:0] pos;
    logic [63:0] whole;
    diff = longint'(query) - longint'(origin);
    if (diff < 0) begin
      w_hi = 0;
      clamped = 1'b1;
      return 0;
    end
    pos = 64'(diff) * {32'd0, inv_step};
    whole = pos >> bti_pkg::POS_FRAC;
    if (whole > 64'(npts - 1) ||
        (whole == 64'(npts - 1) && pos[bti_pkg::POS_FRAC-1:0] != '0)) begin
      w_hi = W_UNIT;
      clamped = 1'b1;
      return npts - 2;
    end
    if (whole == 64'(npts - 1)) begin
      w_hi = W_UNIT;
      return npts - 2;
    end
    w_hi = longint'(pos[bti_pkg::POS_FRAC-1:bti_pkg::POS_FRAC-bti_pkg::WFRAC_W]);
    return whole[31:0];
  endfunction

  function automatic bit locate_query(input bti_pkg::in_item_t it, output int unsigned di,
                                      output int unsigned ti, output longint wd,
                                      output longint wt);
    bit clamped;
    clamped = 1'b0;
    di = find_cell(it.log_density, dens_origin, dens_step, effective_points(dens_pts, DP),
                   wd, clamped);
    ti = find_cell(it.log_temp, temp_origin, temp_step, effective_points(temp_pts, TP),
                   wt, clamped);
    return clamped;
  endfunction

  function automatic longint entry_at(input int unsigned q, input int unsigned d,
                                      input int unsigned t);
    return longint'(entry_mem[entry_index(q, d, t)]);
  endfunction

  function automatic logic signed [31:0] blend_cell(input int unsigned q, input int unsigned di,
                                                   input int unsigned ti, input longint wd1,
                                                   input longint wt1);
    longint wd0, wt0, lo, hi, r;
    wd0 = W_UNIT - wd1;
    wt0 = W_UNIT - wt1;
    lo = round_q20(wt0 * entry_at(q, di, ti) + wt1 * entry_at(q, di, ti + 1));
    hi = round_q20(wt0 * entry_at(q, di + 1, ti) + wt1 * entry_at(q, di + 1, ti + 1));
    r = round_q20(wd0 * lo + wd1 * hi);
    if (r > longint'(Q_MAX)) r = longint'(Q_MAX);
    if (r < longint'(Q_MIN)) r = longint'(Q_MIN);
    return r[31:0];
  endfunction

  task automatic interpolate_item(input bti_pkg::in_item_t it);
    int unsigned di, ti, first, count;
    longint wd, wt;
    bit clamped;
    bti_pkg::out_item_t res;
    case (it.action)
      bti_pkg::ACT_LOAD: begin
        if (it.quantity < NQ)
          entry_mem[entry_index(it.quantity, it.row_density, it.row_temp)] = it.entry_value;
      end
      bti_pkg::ACT_EVAL_ONE, bti_pkg::ACT_EVAL_ALL: begin
        if (it.action == bti_pkg::ACT_EVAL_ALL || it.quantity < NQ) begin
          clamped = locate_query(it, di, ti, wd, wt);
          first = (it.action == bti_pkg::ACT_EVAL_ALL) ? 0 : it.quantity;
          count = (it.action == bti_pkg::ACT_EVAL_ALL) ? NQ : 1;
          for (int unsigned k = 0; k < count; k++) begin
            res.result_value = blend_cell(first + k, di, ti, wd, wt);
            res.result_quantity = 4'(first + k);
            res.last = (k + 1 == count);
            res.out_of_range = clamped;
            expected_blends.push_back(res);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_result(input bti_pkg::out_item_t got);
    bti_pkg::out_item_t want;
    if (expected_blends.size() == 0) begin
      report_mismatch("result with nothing pending", got.result_value, '0);
      return;
    end
    want = expected_blends.pop_front();
    if (got.result_value !== want.result_value)
      report_mismatch("result_value", got.result_value, want.result_value);
    if (got.result_quantity !== want.result_quantity)
      report_mismatch("result_quantity", 32'(got.result_quantity), 32'(want.result_quantity));
    if (got.last !== want.last)
      report_mismatch("last", 32'(got.last), 32'(want.last));
    if (got.out_of_range !== want.out_of_range)
      report_mismatch("out_of_range", 32'(got.out_of_range), 32'(want.out_of_range));
  endtask

  always @(posedge clk) begin
    out_ready <= !out_hold && ($urandom_range(0, 99) >= recv_stall_pct);
    if (rst_n && out_valid && out_ready) check_result(out_data);
  end

  task automatic stop_sending();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  task automatic send_item(input bti_pkg::in_item_t it);
    int gap;
    gap = 0;
    while (gap < 100 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      stop_sending();
      repeat (gap) @(posedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    offering = 1'b1;
    do @(posedge clk); while (!in_ready);
    interpolate_item(it);
  endtask

  task automatic send_load(input logic [3:0] q, input logic [7:0] d, input logic [6:0] t,
                           input logic signed [31:0] value);
    bti_pkg::in_item_t it;
    it.action = bti_pkg::ACT_LOAD;
    it.quantity = q;
    it.row_density = d;
    it.row_temp = t;
    it.entry_value = value;
    it.log_density = $urandom;
    it.log_temp = $urandom;
    send_item(it);
  endtask

  // load every corner the query will read that has not been written yet
  task automatic fill_corners(input bti_pkg::in_item_t it);
    int unsigned di, ti, first, count;
    longint wd, wt;
    bit clamped;
    if (it.action == bti_pkg::ACT_LOAD || it.action == bti_pkg::ACT_NONE) return;
    if (it.action == bti_pkg::ACT_EVAL_ONE && it.quantity >= NQ) return;
    clamped = locate_query(it, di, ti, wd, wt);
    first = (it.action == bti_pkg::ACT_EVAL_ALL) ? 0 : it.quantity;
    count = (it.action == bti_pkg::ACT_EVAL_ALL) ? NQ : 1;
    for (int unsigned q = first; q < first + count; q++)
      for (int unsigned dd = 0; dd < 2; dd++)
        for (int unsigned tt = 0; tt < 2; tt++)
          if (!entry_mem.exists(entry_index(q, di + dd, ti + tt)))
            send_load(4'(q), 8'(di + dd), 7'(ti + tt), $urandom);
  endtask

  task automatic send_query(input bti_pkg::in_item_t it);
    fill_corners(it);
    send_item(it);
  endtask

  task automatic send_eval(input bti_pkg::action_t act, input logic [3:0] q,
                           input logic signed [31:0] dens, input logic signed [31:0] temp);
    bti_pkg::in_item_t it;
    it.action = act;
    it.quantity = q;
    it.row_density = 8'($urandom);
    it.row_temp = 7'($urandom);
    it.entry_value = $urandom;
    it.log_density = dens;
    it.log_temp = temp;
    send_query(it);
  endtask

  function automatic logic signed [31:0] aim_axis(input logic signed [31:0] origin,
                                                 input logic [31:0] inv_step,
                                                 input int unsigned npts);
    int unsigned pick, grid_pt, frac;
    logic [63:0] target, diff;
    longint q;
    pick = $urandom_range(0, 99);
    if (npts == 2 && pick < 40) return $urandom;
    if (pick < 15 && origin != Q_MIN) begin
      q = longint'(origin) - 1 - (longint'($urandom) % (longint'(origin) - longint'(Q_MIN)));
      return q[31:0];
    end
    if (pick < 20) return Q_MAX;
    if (pick < 35) begin
      grid_pt = npts - 1 + $urandom_range(0, 2);
      frac = $urandom_range(0, 1) ? 0 : $urandom_range(0, (1 << bti_pkg::WFRAC_W) - 1);
    end else begin
      grid_pt = $urandom_range(0, 1) ? $urandom_range(0, (npts > 4) ? 2 : npts - 2) : npts - 2;
      frac = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, (1 << bti_pkg::WFRAC_W) - 1);
    end
    target = (64'(grid_pt) << bti_pkg::POS_FRAC) |
             (64'(frac) << (bti_pkg::POS_FRAC - bti_pkg::WFRAC_W));
    if (inv_step == '0) diff = 64'($urandom_range(0, 1 << bti_pkg::WFRAC_W));
    else diff = (target + 64'(inv_step) - 1) / 64'(inv_step);
    q = longint'(origin) + longint'(diff);
    if (q > longint'(Q_MAX)) return Q_MAX;
    return q[31:0];
  endfunction

  function automatic bti_pkg::in_item_t random_item();
    bti_pkg::in_item_t it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    it.quantity = 4'($urandom_range(0, 15));
    it.row_density = 8'($urandom);
    it.row_temp = 7'($urandom);
    it.entry_value = $urandom;
    it.log_density = aim_axis(dens_origin, dens_step, effective_points(dens_pts, DP));
    it.log_temp = aim_axis(temp_origin, temp_step, effective_points(temp_pts, TP));
    if (pick < 8) begin
      it.action = bti_pkg::ACT_LOAD;
    end else if (pick < 13) begin
      it.action = bti_pkg::ACT_NONE;
    end else if (pick < 60) begin
      it.action = bti_pkg::ACT_EVAL_ONE;
      if ($urandom_range(0, 7) != 0) it.quantity = 4'($urandom_range(0, NQ - 1));
    end else begin
      it.action = bti_pkg::ACT_EVAL_ALL;
    end
    return it;
  endfunction

  task automatic run_items(input int n);
    repeat (n) send_query(random_item());
  endtask

  task automatic wait_idle();
    stop_sending();
    while (expected_blends.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bti_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      bti_pkg::CFG_DENSITY_ORIGIN:   dens_origin = value;
      bti_pkg::CFG_DENSITY_INV_STEP: dens_step = value;
      bti_pkg::CFG_DENSITY_POINTS:   dens_pts = value[8:0];
      bti_pkg::CFG_TEMP_ORIGIN:      temp_origin = value;
      bti_pkg::CFG_TEMP_INV_STEP:    temp_step = value;
      bti_pkg::CFG_TEMP_POINTS:      temp_pts = value[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic signed [31:0] d_org, input logic [31:0] d_inv,
                                input logic [8:0] d_pts, input logic signed [31:0] t_org,
                                input logic [31:0] t_inv, input logic [7:0] t_pts);
    write_reg(bti_pkg::CFG_DENSITY_ORIGIN, d_org);
    write_reg(bti_pkg::CFG_DENSITY_INV_STEP, d_inv);
    write_reg(bti_pkg::CFG_DENSITY_POINTS, 32'(d_pts));
    write_reg(bti_pkg::CFG_TEMP_ORIGIN, t_org);
    write_reg(bti_pkg::CFG_TEMP_INV_STEP, t_inv);
    write_reg(bti_pkg::CFG_TEMP_POINTS, 32'(t_pts));
    cfg_we <= 1'b0;
  endtask

  task automatic test_directed();
    bti_pkg::in_item_t noise;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_load(4'd0, 8'd0, 7'd0, Q_MIN);
    send_load(4'd0, 8'd0, 7'd1, Q_MAX);
    send_load(4'd0, 8'd1, 7'd0, Q_MAX);
    send_load(4'd0, 8'd1, 7'd1, Q_MIN);
    send_load(4'd12, 8'd255, 7'd127, Q_MAX);
    send_load(4'd12, 8'd254, 7'd126, Q_MIN);
    send_load(4'd12, 8'd254, 7'd127, -32'sd1);
    send_load(4'd12, 8'd255, 7'd126, '0);
    // loads past the last quantity are dropped
    send_load(4'd13, 8'd0, 7'd0, $urandom);
    send_load(4'd15, 8'd255, 7'd127, $urandom);
    noise = '1;
    noise.action = bti_pkg::ACT_NONE;
    send_item(noise);
    send_eval(bti_pkg::ACT_EVAL_ONE, 4'd0, 32'sh0008_0000, 32'sh0008_0000);
    send_eval(bti_pkg::ACT_EVAL_ONE, 4'd12, 32'sh0FF0_0000, 32'sh07F0_0000);
    send_eval(bti_pkg::ACT_EVAL_ONE, 4'd12, 32'sh0FF0_0001, 32'sh07F0_0000);
    send_eval(bti_pkg::ACT_EVAL_ONE, 4'd0, Q_MIN, '0);
    send_eval(bti_pkg::ACT_EVAL_ONE, 4'd15, '0, '0);
    send_eval(bti_pkg::ACT_EVAL_ALL, 4'd0, 32'sh000F_FFFF, 32'sh000F_FFFF);
    send_eval(bti_pkg::ACT_EVAL_ALL, 4'd9, Q_MAX, Q_MAX);
    send_eval(bti_pkg::ACT_EVAL_ALL, 4'd3, '0, '0);
    wait_idle();
  endtask

  task automatic test_grid_settings();
    send_idle_pct = 24;
    recv_stall_pct = 24;
    // two-point grids, widest origins and steps
    apply_settings(Q_MIN, 32'hFFFF_FFFF, 9'd0, Q_MAX, 32'hFFFF_FFFF, 8'd1);
    run_items(20);
    wait_idle();
    // zero steps, point counts above the table size
    apply_settings($urandom, 32'd0, 9'd511, $urandom, 32'd0, 8'd255);
    run_items(20);
    wait_idle();
    apply_settings(-32'sh0030_0000, 32'h0004_0000, 9'd17, 32'sh0010_0000, 32'h0000_8000, 8'd9);
    run_items(20);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    apply_settings(-32'sh0080_0000, 32'h0002_0000, 9'd256, 32'sh0020_0000, 32'h0000_C000,
                   8'd128);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_items(60);
    send_idle_pct = 86;
    run_items(60);
    send_idle_pct = 0;
    recv_stall_pct = 86;
    run_items(60);
    send_idle_pct = 24;
    recv_stall_pct = 24;
    run_items(60);
    wait_idle();
  endtask

  task automatic test_input_backpressure();
    apply_settings(32'sh0000_0000, 32'h0001_0000, 9'd3, -32'sh0010_0000, 32'h0001_8000, 8'd2);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        out_hold <= 1'b1;
        repeat (500) @(posedge clk);
        out_hold <= 1'b0;
      end
      begin
        repeat (20) send_eval(bti_pkg::ACT_EVAL_ALL, 4'($urandom),
                              aim_axis(dens_origin, dens_step, 3),
                              aim_axis(temp_origin, temp_step, 2));
        stop_sending();
      end
    join
    wait_idle();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_grid_settings();
    test_random_traffic();
    test_input_backpressure();
    if (mismatch_count == 0 && expected_blends.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== bilinear_table_interpolator.f =====
design/bti_pkg.sv
design/bti_axis.sv
design/bti_mac.sv
design/bti_table_mem.sv
design/bilinear_table_interpolator.sv
tb/testbench.sv
